// File: rtl/tks_pkg.sv
// Shared types and constants for the top-k triple sums block.
package tks_pkg;

  localparam int VALUE_BITS_DEF = 40;
  localparam int LIST_DEPTH_DEF = 1024;
  localparam int HEAP_DEPTH_DEF = 4096;

  localparam int CFG_BITS       = 11;
  localparam int CFG_INDEX_BITS = 3;
  localparam int MODE_BITS      = 2;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_LOAD_C  = 2'd2,
    MODE_REQUEST = 2'd3
  } mode_t;

  localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT_A     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT_B     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT_C     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SUMS_WANTED = 3'd3;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 11'd1;

endpackage

// File: rtl/top_k_triple_sums.sv
// Top level of the top-k triple sums block: sorted list stores, candidate heap and seen set.
//
// Three descending lists are built by insertion as elements arrive (tuser 0, 1, 2); a load
// into an empty list writes its element at the head directly, any other load compares the
// stored elements from the tail and shifts each smaller one down in the list memory.
// A request (tuser 3) returns the next largest sum a[i]+b[j]+c[l] over distinct index
// triples, with tuser high when the sum is valid. A request pops the candidate heap (with a
// sift-down through the heap levels on the heap memory's single read port), then for
// each of up to three successor triples scans the seen set (one read per stored triple)
// and pushes the new candidate (a sift-up through the heap levels), so its cost grows
// with the number of triples served so far. Heap and seen set are tracked by fill counts;
// there is no clearing pass after reset. Loads and configuration writes restart the search.
module top_k_triple_sums #(
  parameter int VALUE_BITS = tks_pkg::VALUE_BITS_DEF,
  parameter int LIST_DEPTH = tks_pkg::LIST_DEPTH_DEF,
  parameter int HEAP_DEPTH = tks_pkg::HEAP_DEPTH_DEF,
  localparam int IN_W  = ((VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((VALUE_BITS + 2 + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [IN_W-1:0]                     s_tdata,   // value
  input  logic [tks_pkg::MODE_BITS-1:0]       s_tuser,   // mode
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [OUT_W-1:0]                    m_tdata,   // sum
  output logic [0:0]                          m_tuser,   // valid_res
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tks_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tks_pkg::CFG_BITS-1:0]        cfg_data
);

  import tks_pkg::*;

  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int HA = $clog2(HEAP_DEPTH);
  localparam int HC = $clog2(HEAP_DEPTH + 1);
  localparam int SW = VALUE_BITS + 2;
  localparam int TW = 3 * IW;
  localparam int EW = SW + TW;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_CMP,
    ST_CHECK,
    ST_POP_TOP,
    ST_POP_CUR,
    ST_DN_L,
    ST_DN_R,
    ST_DN_C,
    ST_CAND,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SUM_RD,
    ST_SUM_ADD,
    ST_UP_RD,
    ST_UP_CMP,
    ST_FINISH
  } state_t;

  state_t state;

  logic [CFG_BITS-1:0]   cnt [3];
  logic [CFG_BITS-1:0]   wanted;
  logic [CW-1:0]         loaded [3];
  logic [CW-1:0]         eff [3];
  logic [HC-1:0]         heap_fill;
  logic [HC-1:0]         seen_fill;
  logic [CFG_BITS-1:0]   served;
  logic                  seeded;
  logic                  seeding;
  logic [1:0]            lsel;
  logic [VALUE_BITS-1:0] val;
  logic [IW-1:0]         pos;
  logic [EW-1:0]         top;
  logic [EW-1:0]         cur;
  logic [EW-1:0]         lch;
  logic [EW-1:0]         new_ent;
  logic [HA-1:0]         hi;
  logic [HC-1:0]         j;
  logic [TW-1:0]         key;
  logic [1:0]            k;
  logic [SW-1:0]         res_sum;
  logic                  res_ok;
  logic [SW-1:0]         out_sum;
  logic                  out_ok;

  logic [VALUE_BITS-1:0] lst_mem [3][LIST_DEPTH];
  logic [VALUE_BITS-1:0] lst_q [3];
  logic [IW-1:0]         lst_raddr [3];
  logic                  lst_we;
  logic [IW-1:0]         lst_waddr;
  logic [VALUE_BITS-1:0] lst_wdata;

  logic [EW-1:0]         heap_mem [HEAP_DEPTH];
  logic [EW-1:0]         heap_q;
  logic [HA-1:0]         heap_raddr;
  logic                  heap_we;
  logic [HA-1:0]         heap_waddr;
  logic [EW-1:0]         heap_wdata;

  logic [TW-1:0]         seen_mem [HEAP_DEPTH];
  logic [TW-1:0]         seen_q;
  logic                  seen_we;

  mode_t                 in_mode;
  logic [VALUE_BITS-1:0] in_val;
  logic [IW-1:0]         ia, ib, ic;
  logic [HA+1:0]         l_idx, r_idx;
  logic                  l_ok, r_ok;
  logic [HA-1:0]         par;
  logic [EW-1:0]         best_ent;
  logic [HA-1:0]         best_idx;
  logic                  best_child;
  logic                  j_lt;
  logic                  full;
  logic                  up_wins;
  logic                  load_shift;

  function automatic logic [CW-1:0] clamp_len(input logic [CFG_BITS-1:0] c);
    if (32'(c) > LIST_DEPTH) return CW'(LIST_DEPTH);
    return CW'(c);
  endfunction

  assign in_mode = mode_t'(s_tuser);
  assign in_val  = s_tdata[VALUE_BITS-1:0];

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      eff[x] = (loaded[x] < clamp_len(cnt[x])) ? loaded[x] : clamp_len(cnt[x]);
    end
  end

  assign ia = top[2*IW +: IW];
  assign ib = top[IW +: IW];
  assign ic = top[0 +: IW];

  assign l_idx   = {1'b0, hi, 1'b1};
  assign r_idx   = l_idx + (HA+2)'(1);
  assign l_ok    = l_idx < (HA+2)'(heap_fill);
  assign r_ok    = r_idx < (HA+2)'(heap_fill);
  assign par     = (hi - HA'(1)) >> 1;
  assign j_lt    = j < seen_fill;
  assign full    = (32'(seen_fill) >= HEAP_DEPTH) || (32'(heap_fill) >= HEAP_DEPTH);
  assign up_wins = new_ent > heap_q;
  assign load_shift = lst_q[lsel] < val;

  always_comb begin
    best_ent   = cur;
    best_idx   = hi;
    best_child = 1'b0;
    if (lch > cur) begin
      best_ent   = lch;
      best_idx   = HA'(l_idx);
      best_child = 1'b1;
    end
    if (r_ok && (heap_q > best_ent)) begin
      best_ent   = heap_q;
      best_idx   = HA'(r_idx);
      best_child = 1'b1;
    end
  end

  always_comb begin
    lst_raddr[0] = (state == ST_SUM_RD) ? key[2*IW +: IW] : pos - IW'(1);
    lst_raddr[1] = (state == ST_SUM_RD) ? key[IW +: IW]   : pos - IW'(1);
    lst_raddr[2] = (state == ST_SUM_RD) ? key[0 +: IW]    : pos - IW'(1);
    lst_we    = 1'b0;
    lst_waddr = pos;
    lst_wdata = val;
    if (state == ST_LOAD_RD && pos == '0) begin
      lst_we = 1'b1;
    end else if (state == ST_LOAD_CMP) begin
      lst_we    = 1'b1;
      lst_wdata = load_shift ? lst_q[lsel] : val;
    end
  end

  always_comb begin
    heap_raddr = '0;
    heap_we    = 1'b0;
    heap_waddr = hi;
    heap_wdata = cur;
    case (state)
      ST_POP_TOP: heap_raddr = HA'(heap_fill - HC'(1));
      ST_DN_L: begin
        heap_raddr = HA'(l_idx);
        heap_we    = !l_ok;
      end
      ST_DN_R: heap_raddr = HA'(r_idx);
      ST_DN_C: begin
        heap_we    = 1'b1;
        heap_wdata = best_ent;
      end
      ST_UP_RD: begin
        heap_raddr = par;
        heap_we    = (hi == '0);
        heap_wdata = new_ent;
      end
      ST_UP_CMP: begin
        heap_we    = 1'b1;
        heap_wdata = up_wins ? heap_q : new_ent;
      end
      default: heap_raddr = '0;
    endcase
  end

  assign seen_we = (state == ST_SCAN_RD) && !j_lt && !full;

  always_ff @(posedge clk) begin
    for (int x = 0; x < 3; x++) begin
      if (lst_we && lsel == 2'(x)) lst_mem[x][lst_waddr] <= lst_wdata;
      lst_q[x] <= lst_mem[x][lst_raddr[x]];
    end
  end

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
    heap_q <= heap_mem[heap_raddr];
  end

  always_ff @(posedge clk) begin
    if (seen_we) seen_mem[HA'(seen_fill)] <= key;
    seen_q <= seen_mem[HA'(j)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt[0]    <= CFG_RESET;
      cnt[1]    <= CFG_RESET;
      cnt[2]    <= CFG_RESET;
      wanted    <= CFG_RESET;
      loaded[0] <= '0;
      loaded[1] <= '0;
      loaded[2] <= '0;
      heap_fill <= '0;
      seen_fill <= '0;
      served    <= '0;
      seeded    <= 1'b0;
      seeding   <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_FINISH) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
              REG_COUNT_A:     cnt[0] <= cfg_data;
              REG_COUNT_B:     cnt[1] <= cfg_data;
              REG_COUNT_C:     cnt[2] <= cfg_data;
              REG_SUMS_WANTED: wanted <= cfg_data;
              default:         wanted <= wanted;
            endcase
            if (cfg_index == REG_COUNT_A || cfg_index == REG_COUNT_B ||
                cfg_index == REG_COUNT_C || cfg_index == REG_SUMS_WANTED) begin
              heap_fill <= '0;
              seen_fill <= '0;
              served    <= '0;
              seeded    <= 1'b0;
            end
          end else if (s_tvalid && s_tready) begin
            if (in_mode == MODE_REQUEST) begin
              if (!seeded) begin
                seeded <= 1'b1;
                if (eff[0] != '0 && eff[1] != '0 && eff[2] != '0) begin
                  seeding <= 1'b1;
                  key     <= '0;
                  state   <= ST_SUM_RD;
                end else begin
                  state <= ST_CHECK;
                end
              end else begin
                state <= ST_CHECK;
              end
            end else if (loaded[s_tuser] < clamp_len(cnt[s_tuser])) begin
              lsel  <= s_tuser;
              val   <= in_val;
              pos   <= IW'(loaded[s_tuser]);
              state <= ST_LOAD_RD;
            end
          end
        end
        ST_LOAD_RD: begin
          if (pos == '0) begin
            loaded[lsel] <= loaded[lsel] + CW'(1);
            heap_fill    <= '0;
            seen_fill    <= '0;
            served       <= '0;
            seeded       <= 1'b0;
            state        <= ST_IDLE;
          end else begin
            state <= ST_LOAD_CMP;
          end
        end
        ST_LOAD_CMP: begin
          if (load_shift) begin
            pos   <= pos - IW'(1);
            state <= ST_LOAD_RD;
          end else begin
            loaded[lsel] <= loaded[lsel] + CW'(1);
            heap_fill    <= '0;
            seen_fill    <= '0;
            served       <= '0;
            seeded       <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        ST_CHECK: begin
          if (served >= wanted || heap_fill == '0) begin
            res_sum <= '0;
            res_ok  <= 1'b0;
            state   <= ST_FINISH;
          end else begin
            state <= ST_POP_TOP;
          end
        end
        ST_POP_TOP: begin
          top       <= heap_q;
          heap_fill <= heap_fill - HC'(1);
          k         <= '0;
          state     <= (heap_fill != HC'(1)) ? ST_POP_CUR : ST_CAND;
        end
        ST_POP_CUR: begin
          cur   <= heap_q;
          hi    <= '0;
          state <= ST_DN_L;
        end
        ST_DN_L: begin
          state <= l_ok ? ST_DN_R : ST_CAND;
        end
        ST_DN_R: begin
          lch   <= heap_q;
          state <= ST_DN_C;
        end
        ST_DN_C: begin
          if (best_child) begin
            hi    <= best_idx;
            state <= ST_DN_L;
          end else begin
            state <= ST_CAND;
          end
        end
        ST_CAND: begin
          j <= '0;
          case (k)
            2'd0: begin
              key <= {ia + IW'(1), ib, ic};
              if ((32'(ia) + 1) < 32'(eff[0])) state <= ST_SCAN_RD;
              else k <= k + 2'd1;
            end
            2'd1: begin
              key <= {ia, ib + IW'(1), ic};
              if ((32'(ib) + 1) < 32'(eff[1])) state <= ST_SCAN_RD;
              else k <= k + 2'd1;
            end
            2'd2: begin
              key <= {ia, ib, ic + IW'(1)};
              if ((32'(ic) + 1) < 32'(eff[2])) state <= ST_SCAN_RD;
              else k <= k + 2'd1;
            end
            default: begin
              served  <= served + CFG_BITS'(1);
              res_sum <= top[TW +: SW];
              res_ok  <= 1'b1;
              state   <= ST_FINISH;
            end
          endcase
        end
        ST_SCAN_RD: begin
          if (j_lt) begin
            state <= ST_SCAN_CMP;
          end else if (full) begin
            k     <= k + 2'd1;
            state <= ST_CAND;
          end else begin
            seen_fill <= seen_fill + HC'(1);
            state     <= ST_SUM_RD;
          end
        end
        ST_SCAN_CMP: begin
          if (seen_q == key) begin
            k     <= k + 2'd1;
            state <= ST_CAND;
          end else begin
            j     <= j + HC'(1);
            state <= ST_SCAN_RD;
          end
        end
        ST_SUM_RD: begin
          state <= ST_SUM_ADD;
        end
        ST_SUM_ADD: begin
          new_ent   <= {SW'(lst_q[0]) + SW'(lst_q[1]) + SW'(lst_q[2]), key};
          hi        <= HA'(heap_fill);
          heap_fill <= heap_fill + HC'(1);
          state     <= ST_UP_RD;
        end
        ST_UP_RD: begin
          if (hi == '0) begin
            if (seeding) begin
              seeding <= 1'b0;
              state   <= ST_CHECK;
            end else begin
              k     <= k + 2'd1;
              state <= ST_CAND;
            end
          end else begin
            state <= ST_UP_CMP;
          end
        end
        ST_UP_CMP: begin
          if (up_wins) begin
            hi    <= par;
            state <= ST_UP_RD;
          end else if (seeding) begin
            seeding <= 1'b0;
            state   <= ST_CHECK;
          end else begin
            k     <= k + 2'd1;
            state <= ST_CAND;
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            out_sum  <= res_sum;
            out_ok   <= res_ok;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready  = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign m_tdata   = OUT_W'(out_sum);
  assign m_tuser   = out_ok;

endmodule
